// ===== hw/rtl/wgp_pkg.sv =====
// Shared constants, codes and types of the wavetable grain player.
`timescale 1ns / 1ps

package wgp_pkg;

  // Field widths fixed by the item format
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int LEN_BITS    = 13;
  localparam int IDX_BITS    = 12;
  localparam int PIN_BITS    = 28;
  localparam int KIND_BITS   = 2;
  // Phase holds up to (8191 << FRAC_BITS) - 1
  localparam int PHASE_BITS  = LEN_BITS + FRAC_BITS;

  // Request kinds
  localparam logic [KIND_BITS-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_START   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_PRODUCE = 2'd2;

  // Configuration registers
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERP_ON    = 1'b1;
  localparam logic [LEN_BITS-1:0]     LEN_RESET        = 13'd4096;

  // Result queue depth (power of two), covers the read and blend latency
  localparam int OUT_DEPTH = 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [FRAC_BITS-1:0]          frac_t;
  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic [LEN_BITS-1:0]           len_t;

  // Control that travels alongside the table read data
  typedef struct packed {
    logic  valid;
    frac_t frac;
  } rd_ctl_t;

endpackage

// ===== hw/rtl/wgp_if.sv =====
// Request and result channel interfaces of the wavetable grain player.
`timescale 1ns / 1ps

interface wgp_in_if;
  logic                              valid;
  logic                              ready;
  logic [wgp_pkg::KIND_BITS-1:0]     kind;
  logic [wgp_pkg::IDX_BITS-1:0]      table_index;
  logic signed [wgp_pkg::SAMPLE_BITS-1:0] sample_value;
  logic [wgp_pkg::PIN_BITS-1:0]      start_phase;
  logic [wgp_pkg::PIN_BITS-1:0]      step_rate;

  modport source (
    output valid, kind, table_index, sample_value, start_phase, step_rate,
    input  ready
  );
  modport sink (
    input  valid, kind, table_index, sample_value, start_phase, step_rate,
    output ready
  );
endinterface

interface wgp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [wgp_pkg::SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

// ===== hw/rtl/wavetable_grain_player_top.sv =====
// Top level of the wavetable grain player.
// Usage:
//   in_ch carries requests: kind 0 writes sample_value at table_index, kind 1
//   starts a grain (start_phase, step_rate, both 12.16, clamped below the
//   table length), kind 2 advances the phase and produces one sample.
//   out_ch returns one sample_out per kind 2 request, in request order.
//   cfg_we/cfg_index/cfg_wdata write table_length (index 0) and
//   interpolate_on (index 1); write them only while the block is idle.
// Throughput: one request per cycle while in_ch.ready is high. A produce request
//   passes the table read, the multiply and the round into the queue, each
//   registered, before its result shows on out_ch. An 8 entry result queue
//   with a credit count sets how many produce requests may be outstanding;
//   in_ch.ready drops while eight are outstanding in the pipeline or the
//   queue, which only a stalling receiver brings about.
// Reset: phase, rate, credits and queue clear; table_length goes to 4096,
//   interpolation off. The sample table is not cleared and must be written
//   before the entries a grain reads.
`timescale 1ns / 1ps

module wavetable_grain_player_top #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  wgp_in_if.sink                              in_ch,
  wgp_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [wgp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wgp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(wgp_pkg::OUT_DEPTH) + 1;
  localparam logic [CW-1:0] CRED_FULL = CW'(wgp_pkg::OUT_DEPTH);
  localparam logic [16:0]   DEPTH_W   = 17'(TABLE_DEPTH);
  localparam int LB = wgp_pkg::LEN_BITS;

  wgp_pkg::len_t    table_length_r, len_lo, eff_len;
  logic             interp_on_r;
  logic [CW-1:0]    cred_r, cred_nxt;
  logic             in_acc, prod_acc, out_acc, tbl_we;
  logic             rd_en;
  logic [AW-1:0]    rd_addr_a, rd_addr_b;
  wgp_pkg::rd_ctl_t rd_ctl;
  wgp_pkg::sample_t rd_a, rd_b, blend;
  logic             blend_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= wgp_pkg::LEN_RESET;
      interp_on_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wgp_pkg::CFG_TABLE_LENGTH: table_length_r <= cfg_wdata;
        wgp_pkg::CFG_INTERP_ON:    interp_on_r    <= cfg_wdata[0];
      endcase
    end
  end

  // Clamp length to 2..TABLE_DEPTH
  always_comb begin
    len_lo  = (table_length_r < LB'(2)) ? LB'(2) : table_length_r;
    eff_len = ({4'b0, len_lo} > DEPTH_W) ? DEPTH_W[LB-1:0] : len_lo;
  end

  // Handshakes and credit count of outstanding results
  assign in_ch.ready = (cred_r != CRED_FULL);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign prod_acc    = in_acc && (in_ch.kind == wgp_pkg::KIND_PRODUCE);
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign tbl_we      = in_acc && (in_ch.kind == wgp_pkg::KIND_WRITE) &&
                       ({5'b0, in_ch.table_index} < DEPTH_W);

  always_comb begin
    cred_nxt = cred_r;
    case ({prod_acc, out_acc})
      2'b10:   cred_nxt = cred_r + CW'(1);
      2'b01:   cred_nxt = cred_r - CW'(1);
      default: cred_nxt = cred_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else begin
      cred_r <= cred_nxt;
    end
  end

  wgp_phase #(.TABLE_DEPTH(TABLE_DEPTH)) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .kind        (in_ch.kind),
    .start_phase (in_ch.start_phase),
    .step_rate   (in_ch.step_rate),
    .len         (eff_len),
    .interp_on   (interp_on_r),
    .rd_en       (rd_en),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_ctl_r    (rd_ctl)
  );

  wgp_table_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
    .clk       (clk),
    .we        (tbl_we),
    .waddr     (AW'(in_ch.table_index)),
    .wdata     (in_ch.sample_value),
    .re        (rd_en),
    .raddr_a   (rd_addr_a),
    .raddr_b   (rd_addr_b),
    .rdata_a_r (rd_a),
    .rdata_b_r (rd_b)
  );

  wgp_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rd_ctl),
    .a         (rd_a),
    .b         (rd_b),
    .res_valid (blend_valid),
    .res       (blend)
  );

  wgp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (blend_valid),
    .push_data (blend),
    .out_ch    (out_ch)
  );

  // Credits never exceed the queue depth
  a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= CRED_FULL)
    else $error("credit count above queue depth");

  // A pending result is always covered by a credit
  a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> cred_r != '0)
    else $error("result shown without outstanding credit");

  // A produce request shows as valid read control in the next cycle
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    prod_acc |=> rd_ctl.valid)
    else $error("produce request without table read");

  // A blended result belongs to an outstanding request
  a_blend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    blend_valid |-> cred_r != '0)
    else $error("blend result without outstanding credit");

endmodule

// ===== hw/rtl/wgp_table_ram.sv =====
// Sample table memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module wgp_table_ram #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  wgp_pkg::sample_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output wgp_pkg::sample_t rdata_a_r,
  output wgp_pkg::sample_t rdata_b_r
);

  wgp_pkg::sample_t mem [DEPTH];

  // Write the entry and fetch both neighbors; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

endmodule

// ===== hw/rtl/wgp_phase.sv =====
// Phase accumulator and table read address generation.
`timescale 1ns / 1ps

module wgp_phase #(
  parameter int TABLE_DEPTH = 4096,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc,
  input  logic [wgp_pkg::KIND_BITS-1:0]   kind,
  input  logic [wgp_pkg::PIN_BITS-1:0]    start_phase,
  input  logic [wgp_pkg::PIN_BITS-1:0]    step_rate,
  input  wgp_pkg::len_t                   len,
  input  logic                            interp_on,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr_a,
  output logic [AW-1:0]                   rd_addr_b,
  output wgp_pkg::rd_ctl_t                rd_ctl_r
);

  localparam int PB = wgp_pkg::PHASE_BITS;
  localparam int FB = wgp_pkg::FRAC_BITS;
  localparam int LB = wgp_pkg::LEN_BITS;

  wgp_pkg::phase_t  phase_r, phase_nxt, rate_r, rate_nxt;
  wgp_pkg::phase_t  lfix, lfix_m1, start_clamp, rate_clamp, stepped;
  logic [PB:0]      sum, wrap, lfix_x;
  wgp_pkg::len_t    j, j_lim, j_inc, j_nxt;
  wgp_pkg::rd_ctl_t ctl_nxt;

  // Wrap point in fixed point
  assign lfix    = {len, {FB{1'b0}}};
  assign lfix_m1 = lfix - PB'(1);
  assign lfix_x  = {1'b0, lfix};

  // Clamp grain start values below the wrap point
  always_comb begin
    start_clamp = (PB'(start_phase) > lfix_m1) ? lfix_m1 : PB'(start_phase);
    rate_clamp  = (PB'(step_rate) > lfix_m1) ? lfix_m1 : PB'(step_rate);
  end

  // Advance: add rate, subtract length once, saturate if still too large
  always_comb begin
    sum     = {1'b0, phase_r} + {1'b0, rate_r};
    wrap    = (sum >= lfix_x) ? sum - lfix_x : sum;
    stepped = (wrap >= lfix_x) ? lfix_m1 : wrap[PB-1:0];
  end

  // Entry pair addresses, second one wraps to entry 0
  always_comb begin
    j     = stepped[PB-1:FB];
    j_lim = (j >= len) ? len - LB'(1) : j;
    j_inc = j_lim + LB'(1);
    j_nxt = (j_inc >= len) ? '0 : j_inc;
  end

  assign rd_addr_a = AW'(j_lim);
  assign rd_addr_b = AW'(j_nxt);

  // Next phase and rate per request kind
  always_comb begin
    phase_nxt = phase_r;
    rate_nxt  = rate_r;
    if (acc) begin
      case (kind)
        wgp_pkg::KIND_START: begin
          phase_nxt = start_clamp;
          rate_nxt  = rate_clamp;
        end
        wgp_pkg::KIND_PRODUCE: begin
          phase_nxt = stepped;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // A zero fraction turns the blend into the lower entry
  always_comb begin
    ctl_nxt.valid = acc && (kind == wgp_pkg::KIND_PRODUCE);
    ctl_nxt.frac  = interp_on ? stepped[FB-1:0] : '0;
  end

  assign rd_en = ctl_nxt.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      rate_r   <= '0;
      rd_ctl_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      rate_r   <= rate_nxt;
      rd_ctl_r <= ctl_nxt;
    end
  end

endmodule

// ===== hw/rtl/wgp_interp.sv =====
// Linear blend of two table entries: multiply stage, then round stage.
`timescale 1ns / 1ps

module wgp_interp (
  input  logic             clk,
  input  logic             rst_n,
  input  wgp_pkg::rd_ctl_t ctl,
  input  wgp_pkg::sample_t a,
  input  wgp_pkg::sample_t b,
  output logic             res_valid,
  output wgp_pkg::sample_t res
);

  localparam int SB = wgp_pkg::SAMPLE_BITS;
  localparam int FB = wgp_pkg::FRAC_BITS;
  localparam int PW = SB + FB + 2;
  localparam logic signed [PW-1:0] HALF =
    {{(PW - FB){1'b0}}, 1'b1, {(FB - 1){1'b0}}};

  logic signed [SB:0]   diff;
  logic signed [PW-1:0] prod, prod_r, a_sh, total;
  wgp_pkg::sample_t     a_r;
  logic                 valid_r;

  // a*(1-f) + b*f rewritten as a + (b-a)*f
  always_comb begin
    diff = $signed({b[SB-1], b}) - $signed({a[SB-1], a});
    prod = diff * $signed({1'b0, ctl.frac});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.valid;
    end
  end

  // Hold product and lower entry for the rounding stage
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prod_r <= prod;
      a_r    <= a;
    end
  end

  // Round half up and drop the fraction
  always_comb begin
    a_sh  = {{2{a_r[SB-1]}}, a_r, {FB{1'b0}}};
    total = a_sh + prod_r + HALF;
  end

  assign res       = total[FB +: SB];
  assign res_valid = valid_r;

endmodule

// ===== hw/rtl/wgp_out_fifo.sv =====
// Result queue that decouples the blend pipeline from the receiver.
`timescale 1ns / 1ps

module wgp_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wgp_pkg::sample_t push_data,
  wgp_out_if.source        out_ch
);

  localparam int DEPTH = wgp_pkg::OUT_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  wgp_pkg::sample_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             pop;

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.sample_out = mem[rd_ptr_r];
  assign pop               = out_ch.valid && out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + (AW + 1)'(1);
      2'b01:   cnt_nxt = cnt_r - (AW + 1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Store the incoming result
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== tb/tb_wavetable_grain_player_top.sv =====
// Self-checking testbench for the wavetable grain player: directed and random requests.
`timescale 1ns / 1ps

// Tracks table, phase and settings; predicts every produced sample and checks results
class grain_scoreboard;
  localparam int DEPTH = 4096;

  logic [wgp_pkg::SAMPLE_BITS-1:0] sample_mem [DEPTH];
  bit                              written [DEPTH];
  wgp_pkg::len_t                   length_cfg;
  bit                              interp_cfg;
  logic [wgp_pkg::PIN_BITS-1:0]    phase;
  logic [wgp_pkg::PIN_BITS-1:0]    rate;
  wgp_pkg::sample_t                expected_samples [$];
  int                              errors;

  function new();
    foreach (written[i]) written[i] = 1'b0;
    phase      = '0;
    rate       = '0;
    length_cfg = wgp_pkg::LEN_RESET;
    interp_cfg = 1'b0;
    errors     = 0;
  endfunction

  // Clamp the programmed length to 2..DEPTH
  function wgp_pkg::len_t used_length();
    if (length_cfg < 2) return wgp_pkg::len_t'(2);
    if (length_cfg > wgp_pkg::len_t'(DEPTH)) return wgp_pkg::len_t'(DEPTH);
    return length_cfg;
  endfunction

  // Phase after one produce request: add rate, wrap once, saturate if still too large
  function logic [29:0] advanced_phase();
    logic [29:0] lfix;
    logic [29:0] sum;
    lfix = {1'b0, used_length(), {wgp_pkg::FRAC_BITS{1'b0}}};
    sum  = 30'(phase) + 30'(rate);
    if (sum >= lfix) sum = sum - lfix;
    if (sum >= lfix) sum = lfix - 30'd1;
    return sum;
  endfunction

  // Table entries read for a given phase: integer part and its wrapped neighbor
  function void read_positions(input logic [29:0] p, output int unsigned j,
                               output int unsigned nx);
    int unsigned len;
    len = 32'(used_length());
    j   = 32'(p >> wgp_pkg::FRAC_BITS);
    if (j >= len) j = len - 1;
    nx = j + 1;
    if (nx >= len) nx = 0;
  endfunction

  function void set_config(logic [wgp_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [wgp_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      wgp_pkg::CFG_TABLE_LENGTH: length_cfg = data;
      wgp_pkg::CFG_INTERP_ON:    interp_cfg = data[0];
      default: ;
    endcase
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function void note_request(logic [wgp_pkg::KIND_BITS-1:0] kind,
                             logic [wgp_pkg::IDX_BITS-1:0] idx,
                             wgp_pkg::sample_t value, logic [wgp_pkg::PIN_BITS-1:0] sp,
                             logic [wgp_pkg::PIN_BITS-1:0] sr);
    logic [29:0]                     limit;
    logic [29:0]                     p;
    int unsigned                     j;
    int unsigned                     nx;
    logic [wgp_pkg::SAMPLE_BITS-1:0] a_u;
    logic [wgp_pkg::SAMPLE_BITS-1:0] b_u;
    logic [16:0]                     f;
    logic [32:0]                     acc;
    limit = {1'b0, used_length(), {wgp_pkg::FRAC_BITS{1'b0}}} - 30'd1;
    case (kind)
      wgp_pkg::KIND_WRITE: begin
        sample_mem[idx] = value;
        written[idx]    = 1'b1;
      end
      wgp_pkg::KIND_START: begin
        phase = (30'(sp) > limit) ? limit[wgp_pkg::PIN_BITS-1:0] : sp;
        rate  = (30'(sr) > limit) ? limit[wgp_pkg::PIN_BITS-1:0] : sr;
      end
      wgp_pkg::KIND_PRODUCE: begin
        p     = advanced_phase();
        phase = p[wgp_pkg::PIN_BITS-1:0];
        read_positions(p, j, nx);
        if (interp_cfg) begin
          // Blend in offset binary, round half up
          a_u = sample_mem[j] ^ 16'h8000;
          b_u = sample_mem[nx] ^ 16'h8000;
          f   = {1'b0, p[wgp_pkg::FRAC_BITS-1:0]};
          acc = a_u * (17'h10000 - f) + b_u * f + 33'h8000;
          expected_samples.push_back(wgp_pkg::sample_t'(acc[31:16] ^ 16'h8000));
        end else begin
          expected_samples.push_back(wgp_pkg::sample_t'(sample_mem[j]));
        end
      end
      default: ;
    endcase
  endfunction

  function void check_sample(wgp_pkg::sample_t got);
    wgp_pkg::sample_t want;
    if (expected_samples.size() == 0) begin
      flag($sformatf("unexpected sample: actual %0d", got));
      return;
    end
    want = expected_samples.pop_front();
    if (got !== want)
      flag($sformatf("sample mismatch: expected %0d actual %0d", want, got));
  endfunction

  function void flag_leftover();
    while (expected_samples.size() != 0)
      flag($sformatf("missing sample: expected %0d", expected_samples.pop_front()));
  endfunction

  function int pending();
    return expected_samples.size();
  endfunction
endclass

module tb_wavetable_grain_player_top;
  localparam logic [wgp_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam int IB = wgp_pkg::IDX_BITS;
  localparam int SB = wgp_pkg::SAMPLE_BITS;
  localparam int PB = wgp_pkg::PIN_BITS;
  localparam int FB = wgp_pkg::FRAC_BITS;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [wgp_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [wgp_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int rx_hold       = 0;
  int item_count    = 0;

  grain_scoreboard board = new();

  wgp_in_if  in_ch();
  wgp_out_if out_ch();

  wavetable_grain_player_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: hold off for a counted stretch when asked, else stall at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_sample(out_ch.sample_out);
  end

  // Offer one request, idling first at random; note it once accepted
  task automatic send_request(logic [wgp_pkg::KIND_BITS-1:0] kind, logic [IB-1:0] idx,
                              logic [SB-1:0] value, logic [PB-1:0] sp,
                              logic [PB-1:0] sr);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.table_index  <= idx;
    in_ch.sample_value <= value;
    in_ch.start_phase  <= sp;
    in_ch.step_rate    <= sr;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    board.note_request(kind, idx, value, sp, sr);
    if (kind != KIND_UNUSED) item_count++;
  endtask

  task automatic send_write(int unsigned idx, logic [SB-1:0] value);
    send_request(wgp_pkg::KIND_WRITE, IB'(idx), value, PB'($urandom()), PB'($urandom()));
  endtask

  task automatic send_start(logic [PB-1:0] sp, logic [PB-1:0] sr);
    send_request(wgp_pkg::KIND_START, IB'($urandom()), SB'($urandom()), sp, sr);
  endtask

  // Produce one sample; write any entry it reads that was never written
  task automatic produce_one();
    int unsigned j;
    int unsigned nx;
    read_positions_wrap(j, nx);
    if (!board.written[j]) send_write(j, SB'($urandom()));
    if (!board.written[nx]) send_write(nx, SB'($urandom()));
    send_request(wgp_pkg::KIND_PRODUCE, IB'($urandom()), SB'($urandom()),
                 PB'($urandom()), PB'($urandom()));
  endtask

  task automatic read_positions_wrap(output int unsigned j, output int unsigned nx);
    board.read_positions(board.advanced_phase(), j, nx);
  endtask

  // Drop valid and wait until every expected sample has arrived, plus pipeline slack
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both registers on consecutive edges
  task automatic write_settings(wgp_pkg::len_t len, logic interp);
    cfg_we    <= 1'b1;
    cfg_index <= wgp_pkg::CFG_TABLE_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    board.set_config(wgp_pkg::CFG_TABLE_LENGTH, len);
    cfg_index <= wgp_pkg::CFG_INTERP_ON;
    cfg_wdata <= {{(wgp_pkg::CFG_DATA_BITS-1){1'b0}}, interp};
    @(posedge clk);
    board.set_config(wgp_pkg::CFG_INTERP_ON, {{(wgp_pkg::CFG_DATA_BITS-1){1'b0}}, interp});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PB-1:0] pick_rate();
    int unsigned len;
    len = 32'(board.used_length());
    case ($urandom_range(3))
      0: return PB'($urandom());
      1: return PB'($urandom_range(0, 2 << FB));
      2: return PB'($urandom_range(0, len - 1) << FB);
      default: return PB'($urandom_range(0, (len << FB) - 1));
    endcase
  endfunction

  function automatic logic [PB-1:0] pick_phase();
    int unsigned len;
    len = 32'(board.used_length());
    if ($urandom_range(1)) return PB'($urandom());
    return PB'($urandom_range(0, (len << FB) - 1));
  endfunction

  // Extremes of the fields, wrap, saturation and the rounding midpoint
  task automatic run_directed();
    send_write(0, 16'h8000);
    send_write(4095, 16'h7FFF);
    send_write(1, 16'h0000);
    send_request(KIND_UNUSED, '1, '1, '1, '1);
    produce_one();
    send_start('1, '0);
    produce_one();
    send_start('0, '1);
    produce_one();
    produce_one();
    send_start(28'h0FFF0000, '0);
    produce_one();
    wait_drained();
    // Length drops under a running grain: phase saturates
    write_settings(13'd2, 1'b1);
    produce_one();
    send_write(0, 16'h8000);
    send_write(1, 16'h7FFF);
    send_start(28'h0008000, 28'h0010000);
    produce_one();
    produce_one();
    send_start('0, 28'h0004000);
    produce_one();
    produce_one();
  endtask

  // One setting of the registers and of the idling, then random grains
  task automatic run_phase(wgp_pkg::len_t len, logic interp, int in_pct, int out_pct,
                           int n_items, bit pressure);
    int first;
    int r;
    wait_drained();
    write_settings(len, interp);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    if (pressure) rx_hold = 400;
    first = item_count;
    while (item_count - first < n_items) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_start(pick_phase(), pick_rate());
        repeat ($urandom_range(2, 16)) produce_one();
      end else if (r < 80) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(3) != 0)
            send_write($urandom_range(0, 32'(board.used_length()) - 1), SB'($urandom()));
          else
            send_write($urandom_range(0, 4095), SB'($urandom()));
        end
      end else if (r < 93) begin
        produce_one();
      end else begin
        send_request(KIND_UNUSED, IB'($urandom()), SB'($urandom()), PB'($urandom()),
                     PB'($urandom()));
      end
    end
  endtask

  initial begin
    int guard;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= wgp_pkg::CFG_TABLE_LENGTH;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= wgp_pkg::KIND_WRITE;
    in_ch.table_index  <= '0;
    in_ch.sample_value <= '0;
    in_ch.start_phase  <= '0;
    in_ch.step_rate    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_phase(13'd4096, 1'b0, 0, 0, 150, 1'b0);
    run_phase(13'd2, 1'b1, 79, 0, 150, 1'b0);
    run_phase(13'd16, 1'b1, 0, 79, 150, 1'b0);
    run_phase(13'd1, 1'b0, 8, 8, 140, 1'b0);
    run_phase(13'd8191, 1'b1, 0, 0, 150, 1'b1);
    run_phase(13'd0, 1'b1, 79, 0, 140, 1'b0);
    run_phase(wgp_pkg::len_t'($urandom_range(2, 64)), 1'b0, 0, 79, 140, 1'b0);
    run_phase(13'd3, 1'b1, 8, 8, 140, 1'b0);
    run_phase(wgp_pkg::len_t'($urandom()), 1'b1, 0, 0, 140, 1'b0);

    // Drain, then allow the pipeline to settle
    in_ch.valid <= 1'b0;
    guard = 0;
    while (board.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    board.flag_leftover();
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
